@@ src/opx_pkg.sv @@
`default_nettype none

package opx_pkg;

  localparam int unsigned GENE_W     = 5;
  localparam int unsigned TYPE_COUNT = 1 << GENE_W;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  typedef logic [GENE_W-1:0] gene_t;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_e;

  // one-hot sequencer codes
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_MARK_RD = 7'b0000010,
    ST_MARK_WR = 7'b0000100,
    ST_FILL_RD = 7'b0001000,
    ST_FILL_WR = 7'b0010000,
    ST_EMIT_RD = 7'b0100000,
    ST_EMIT_WR = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

@@ src/opx_gene_ram.sv @@
`default_nettype none

module opx_gene_ram #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire opx_pkg::gene_t wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output opx_pkg::gene_t     rdata_o
);
  import opx_pkg::*;

  gene_t mem [DEPTH];
  gene_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/ordered_permutation_crossover_core.sv @@
// Ordered crossover (OX1) of two permutation genomes held in on-chip gene stores.
// Input stream (s_axis): tuser selects the word kind. A load word writes one gene of
// each parent at a position and produces no output; a run word carries two cut points
// and starts a crossover of the first gene_count genes.
// Output stream (m_axis): one word per gene position, in position order, carrying
// both children's genes; tlast marks the final position of a run.
// Config: cfg_we_i writes gene_count (clamped to 3..MAX_GENES when used).
// In a run a single sequencer walks the cut to mark used gene types, then all
// positions to build the fill lists, then all positions to emit; every step has a
// read state and a write state because every store read is registered.
// s_axis_tready is high only while the sequencer is idle, so one word at a time.
// Results leave through a one-word output register; a stalled receiver holds the
// emit step, nothing is dropped, and the next input word is taken while the final
// result still waits. Reset empties the output register, clears the used marks and
// sets gene_count to 32; gene stores are not cleared and must be loaded before use.
`default_nettype none

module ordered_permutation_crossover_core #(
  parameter int unsigned MAX_GENES = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // cfg: gene_count
  input  wire logic                           cfg_we_i,
  input  wire logic [opx_pkg::CFG_W-1:0]      cfg_wdata_i,
  // tdata: position[4:0], parent_one_gene[9:5], parent_two_gene[14:10],
  //        cut_left[19:15], cut_right[24:20], zero fill [31:25]
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [opx_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op[0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: out_position[4:0], child_one_gene[9:5], child_two_gene[14:10], zero [15]
  output logic [opx_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);
  import opx_pkg::*;

  localparam int unsigned AW = $clog2(MAX_GENES);
  localparam int unsigned CW = $clog2(MAX_GENES + 1);
  localparam int unsigned NW = (CW > CFG_W) ? CW : CFG_W;

  // input word fields
  gene_t s_pos, s_g1, s_g2, s_cl, s_cr;
  op_e   s_op;

  assign s_pos = s_axis_tdata[4:0];
  assign s_g1  = s_axis_tdata[9:5];
  assign s_g2  = s_axis_tdata[14:10];
  assign s_cl  = s_axis_tdata[19:15];
  assign s_cr  = s_axis_tdata[24:20];
  assign s_op  = op_e'(s_axis_tuser);

  state_e state_q, state_d;
  logic [CFG_W-1:0] gene_count_q;
  logic [CW-1:0] n_q, n_d, l_q, l_d, r_q, r_d;
  logic [CW-1:0] idx_q, idx_d, k_q, k_d;
  logic [CW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [TYPE_COUNT-1:0] used1_q, used1_d, used2_q, used2_d;

  logic out_valid_q, out_valid_d;
  gene_t out_pos_q, out_pos_d, out_c1_q, out_c1_d, out_c2_q, out_c2_d;
  logic out_last_q, out_last_d;

  logic accept, out_free;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // run set-up: clamp gene count and cut points
  logic [NW-1:0] gc_ext, n_full, hi_n, cl_c, cr_c, l_n, r_n;
  always_comb begin
    gc_ext = NW'(gene_count_q);
    if (gc_ext < NW'(3)) begin
      n_full = NW'(3);
    end else if (gc_ext > NW'(MAX_GENES)) begin
      n_full = NW'(MAX_GENES);
    end else begin
      n_full = gc_ext;
    end
    hi_n = n_full - NW'(2);
    cl_c = NW'(s_cl);
    if (cl_c < NW'(1)) cl_c = NW'(1);
    else if (cl_c > hi_n) cl_c = hi_n;
    cr_c = NW'(s_cr);
    if (cr_c < NW'(1)) cr_c = NW'(1);
    else if (cr_c > hi_n) cr_c = hi_n;
    if (cl_c == cr_c) cr_c = cl_c + NW'(1);
    if (cl_c > cr_c) begin
      l_n = cr_c;
      r_n = cl_c;
    end else begin
      l_n = cl_c;
      r_n = cr_c;
    end
  end

  // parent stores and fill lists
  logic  load_we;
  gene_t p1_rd, p2_rd, f1_rd, f2_rd;
  logic  f1_we, f2_we;

  assign load_we = accept && (s_op == OP_LOAD) && (32'(s_pos) < MAX_GENES);
  assign f1_we   = (state_q == ST_FILL_WR) && !used1_q[p2_rd];
  assign f2_we   = (state_q == ST_FILL_WR) && !used2_q[p1_rd];

  opx_gene_ram #(.DEPTH(MAX_GENES)) u_p1_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(s_pos)),
    .wdata_i (s_g1),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (p1_rd)
  );

  opx_gene_ram #(.DEPTH(MAX_GENES)) u_p2_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(s_pos)),
    .wdata_i (s_g2),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (p2_rd)
  );

  // child one takes parent two's leftovers, child two parent one's
  opx_gene_ram #(.DEPTH(MAX_GENES)) u_fill1 (
    .clk_i   (clk_i),
    .we_i    (f1_we),
    .waddr_i (cnt1_q[AW-1:0]),
    .wdata_i (p2_rd),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (f1_rd)
  );

  opx_gene_ram #(.DEPTH(MAX_GENES)) u_fill2 (
    .clk_i   (clk_i),
    .we_i    (f2_we),
    .waddr_i (cnt2_q[AW-1:0]),
    .wdata_i (p1_rd),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (f2_rd)
  );

  logic in_cut, at_end;
  assign in_cut = (idx_q >= l_q) && (idx_q <= r_q);
  assign at_end = (idx_q == n_q - CW'(1));

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    l_d         = l_q;
    r_d         = r_q;
    idx_d       = idx_q;
    k_d         = k_q;
    cnt1_d      = cnt1_q;
    cnt2_d      = cnt2_q;
    used1_d     = used1_q;
    used2_d     = used2_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_pos_d   = out_pos_q;
    out_c1_d    = out_c1_q;
    out_c2_d    = out_c2_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (s_op == OP_RUN)) begin
          n_d     = CW'(n_full);
          l_d     = CW'(l_n);
          r_d     = CW'(r_n);
          idx_d   = CW'(l_n);
          used1_d = '0;
          used2_d = '0;
          state_d = ST_MARK_RD;
        end
      end
      ST_MARK_RD: state_d = ST_MARK_WR;
      ST_MARK_WR: begin
        used1_d[p1_rd] = 1'b1;
        used2_d[p2_rd] = 1'b1;
        if (idx_q == r_q) begin
          idx_d   = '0;
          cnt1_d  = '0;
          cnt2_d  = '0;
          state_d = ST_FILL_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_MARK_RD;
        end
      end
      ST_FILL_RD: state_d = ST_FILL_WR;
      ST_FILL_WR: begin
        if (f1_we) cnt1_d = cnt1_q + CW'(1);
        if (f2_we) cnt2_d = cnt2_q + CW'(1);
        if (at_end) begin
          idx_d   = '0;
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_FILL_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = idx_q[GENE_W-1:0];
          out_last_d  = at_end;
          if (in_cut) begin
            out_c1_d = p1_rd;
            out_c2_d = p2_rd;
          end else begin
            out_c1_d = (k_q < cnt1_q) ? f1_rd : '0;
            out_c2_d = (k_q < cnt2_q) ? f2_rd : '0;
            k_d      = k_q + CW'(1);
          end
          if (at_end) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gene_count_q <= CFG_W'(32);
      used1_q      <= '0;
      used2_q      <= '0;
      out_valid_q  <= 1'b0;
      n_q          <= '0;
      l_q          <= '0;
      r_q          <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      cnt1_q       <= '0;
      cnt2_q       <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) gene_count_q <= cfg_wdata_i;
      used1_q     <= used1_d;
      used2_q     <= used2_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      l_q         <= l_d;
      r_q         <= r_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    out_pos_q  <= out_pos_d;
    out_c1_q   <= out_c1_d;
    out_c2_q   <= out_c2_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_c2_q, out_c1_q, out_pos_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import opx_pkg::*;

  localparam int unsigned GENE_SLOTS    = 32;
  localparam int unsigned ITEM_TARGET   = 500;
  // comfortably longer than a full run at 32 genes
  localparam int unsigned SETTLE_CYCLES = 256;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned TIMEOUT_NS    = 4_000_000;

  typedef struct packed {
    logic [4:0] position;
    gene_t      child_one;
    gene_t      child_two;
    logic       last;
  } child_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // shadow of the block: gene stores and gene count as last written
  gene_t            parent_one_genes [GENE_SLOTS];
  gene_t            parent_two_genes [GENE_SLOTS];
  logic [CFG_W-1:0] gene_count_setting = 6'd32;
  child_word_t      children_due [$];

  gene_t       plan_one [GENE_SLOTS];
  gene_t       plan_two [GENE_SLOTS];
  int unsigned words_sent   = 0;
  int unsigned mismatches   = 0;
  bit          no_idling    = 1'b0;
  bit          hold_request = 1'b0;

  ordered_permutation_crossover_core #(
    .MAX_GENES(GENE_SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly cut points inside the legal window, sometimes anything the field holds
  function automatic logic [4:0] pick_cut(int unsigned n);
    if ($urandom_range(9, 0) < 7) return 5'($urandom_range(n - 2, 1));
    return 5'($urandom_range(31, 0));
  endfunction

  // OX1: both children of the current stores, one word per position
  task automatic predict_crossover(input logic [4:0] cut_a, input logic [4:0] cut_b);
    int unsigned n, lo, hi, spare, i, k, len_one, len_two;
    bit          marked_one [TYPE_COUNT];
    bit          marked_two [TYPE_COUNT];
    gene_t       fill_one [GENE_SLOTS];
    gene_t       fill_two [GENE_SLOTS];
    child_word_t word;
    n  = clamp_range(32'(gene_count_setting), 3, GENE_SLOTS);
    lo = clamp_range(32'(cut_a), 1, n - 2);
    hi = clamp_range(32'(cut_b), 1, n - 2);
    if (lo == hi) hi = lo + 1;
    if (lo > hi) begin
      spare = lo;
      lo    = hi;
      hi    = spare;
    end
    for (i = 0; i < TYPE_COUNT; i++) begin
      marked_one[i] = 1'b0;
      marked_two[i] = 1'b0;
    end
    for (i = lo; i <= hi; i++) begin
      marked_one[parent_one_genes[i]] = 1'b1;
      marked_two[parent_two_genes[i]] = 1'b1;
    end
    // fill lists keep duplicates; a short list leaves zero genes behind
    len_one = 0;
    len_two = 0;
    for (i = 0; i < n; i++) begin
      if (!marked_one[parent_two_genes[i]]) begin
        fill_one[len_one] = parent_two_genes[i];
        len_one++;
      end
      if (!marked_two[parent_one_genes[i]]) begin
        fill_two[len_two] = parent_one_genes[i];
        len_two++;
      end
    end
    k = 0;
    for (i = 0; i < n; i++) begin
      word.position = 5'(i);
      if (i >= lo && i <= hi) begin
        word.child_one = parent_one_genes[i];
        word.child_two = parent_two_genes[i];
      end else begin
        word.child_one = (k < len_one) ? fill_one[k] : '0;
        word.child_two = (k < len_two) ? fill_two[k] : '0;
        k++;
      end
      word.last = (i == n - 1);
      children_due.insert(children_due.size(), word);
    end
  endtask

  // offers one word, waits for the handshake, then updates the shadow
  task automatic send_word(input op_e op, input logic [4:0] position, input gene_t gene_one,
                           input gene_t gene_two, input logic [4:0] cut_a,
                           input logic [4:0] cut_b);
    if (!no_idling && $urandom_range(99, 0) < 33) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= 1'($urandom);
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, cut_b, cut_a, gene_two, gene_one, position};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_LOAD) begin
      parent_one_genes[position] = gene_one;
      parent_two_genes[position] = gene_two;
    end else begin
      predict_crossover(cut_a, cut_b);
    end
    words_sent++;
  endtask

  task automatic load_word(input logic [4:0] position, input gene_t gene_one,
                           input gene_t gene_two);
    send_word(OP_LOAD, position, gene_one, gene_two, 5'($urandom), 5'($urandom));
  endtask

  task automatic run_word(input logic [4:0] cut_a, input logic [4:0] cut_b);
    send_word(OP_RUN, 5'($urandom), 5'($urandom), 5'($urandom), cut_a, cut_b);
  endtask

  // block idle: all children back, plus room for a trailing load
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (children_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gene_count(input logic [CFG_W-1:0] value);
    settle_block();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i           <= 1'b0;
    gene_count_setting = value;
  endtask

  // load a fresh pair of parents at 0..n-1 in shuffled order, then a few runs
  task automatic random_round();
    int unsigned n, i, j, runs, spare;
    bit          well_formed;
    gene_t       swap_gene;
    logic [4:0]  order [GENE_SLOTS];
    n           = clamp_range(32'(gene_count_setting), 3, GENE_SLOTS);
    well_formed = ($urandom_range(99, 0) < 80);
    for (i = 0; i < GENE_SLOTS; i++) plan_one[i] = gene_t'(i);
    for (i = GENE_SLOTS - 1; i > 0; i--) begin
      j           = $urandom_range(i, 0);
      swap_gene   = plan_one[i];
      plan_one[i] = plan_one[j];
      plan_one[j] = swap_gene;
    end
    // parent two: same gene set over the first n positions, other order
    plan_two = plan_one;
    for (i = n - 1; i > 0; i--) begin
      j           = $urandom_range(i, 0);
      swap_gene   = plan_two[i];
      plan_two[i] = plan_two[j];
      plan_two[j] = swap_gene;
    end
    if (!well_formed) begin
      for (i = 0; i < GENE_SLOTS; i++) begin
        if ($urandom_range(1, 0) == 0) plan_one[i] = 5'($urandom);
        if ($urandom_range(1, 0) == 0) plan_two[i] = 5'($urandom);
      end
    end
    for (i = 0; i < n; i++) order[i] = 5'(i);
    for (i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i, 0);
      spare    = 32'(order[i]);
      order[i] = order[j];
      order[j] = 5'(spare);
    end
    for (i = 0; i < n; i++) load_word(order[i], plan_one[order[i]], plan_two[order[i]]);
    if (n < GENE_SLOTS && $urandom_range(3, 0) == 0) begin
      j = $urandom_range(GENE_SLOTS - 1, n);
      load_word(5'(j), plan_one[j], plan_two[j]);
    end
    runs = $urandom_range(4, 1);
    for (i = 0; i < runs; i++) begin
      // now and then a stray load breaks the permutation between runs
      if ($urandom_range(9, 0) == 0) load_word(5'($urandom_range(n - 1, 0)), 5'($urandom),
                                               5'($urandom));
      run_word(pick_cut(n), pick_cut(n));
    end
  endtask

  task automatic test_smallest_genome();
    write_gene_count(6'd3);
    load_word(5'd0, 5'd0, 5'd31);
    load_word(5'd1, 5'd31, 5'd5);
    load_word(5'd2, 5'd5, 5'd0);
    run_word(5'd0, 5'd31);
    run_word(5'd1, 5'd1);
    run_word(5'd2, 5'd1);
  endtask

  // positions 0..2 already hold 0, 31, 5 / 31, 5, 0
  task automatic test_cut_points();
    write_gene_count(6'd8);
    load_word(5'd3, 5'd1, 5'd6);
    load_word(5'd4, 5'd2, 5'd4);
    load_word(5'd5, 5'd3, 5'd3);
    load_word(5'd6, 5'd4, 5'd2);
    load_word(5'd7, 5'd6, 5'd1);
    run_word(5'd2, 5'd5);
    run_word(5'd5, 5'd2);
    run_word(5'd4, 5'd4);
    run_word(5'd0, 5'd0);
    run_word(5'd31, 5'd31);
    run_word(5'd30, 5'd1);
  endtask

  // duplicate genes: one fill list too long, the other empty
  task automatic test_broken_parents();
    write_gene_count(6'd0);
    load_word(5'd0, 5'd7, 5'd9);
    load_word(5'd1, 5'd7, 5'd9);
    load_word(5'd2, 5'd7, 5'd7);
    run_word(5'd1, 5'd1);
  endtask

  task automatic test_steady_stream();
    write_gene_count(6'd20);
    no_idling = 1'b1;
    repeat (3) random_round();
    settle_block();
    no_idling = 1'b0;
  endtask

  // receiver holds off while runs keep coming, so the input stalls
  task automatic test_output_backpressure();
    int unsigned n;
    settle_block();
    n            = clamp_range(32'(gene_count_setting), 3, GENE_SLOTS);
    no_idling    = 1'b1;
    hold_request = 1'b1;
    run_word(pick_cut(n), pick_cut(n));
    run_word(pick_cut(n), pick_cut(n));
    load_word(5'($urandom_range(n - 1, 0)), 5'($urandom), 5'($urandom));
    run_word(pick_cut(n), pick_cut(n));
    settle_block();
    no_idling = 1'b0;
  endtask

  task automatic test_random_rounds();
    write_gene_count(6'd63);
    random_round();
    write_gene_count(6'd32);
    random_round();
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(2, 0) == 0) begin
        case ($urandom_range(9, 0))
          0:       write_gene_count(6'd0);
          1:       write_gene_count(6'd2);
          2:       write_gene_count(6'd33);
          3:       write_gene_count(6'd63);
          4:       write_gene_count(6'd3);
          default: write_gene_count(6'($urandom_range(32, 3)));
        endcase
      end
      random_round();
    end
  endtask

  initial begin : receiver
    int unsigned held;
    held          = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (held != 0) begin
        held--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request  = 1'b0;
        held          = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (no_idling) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= 33);
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned expected,
                               input int unsigned actual);
    if (expected != actual) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, expected, actual);
    end
  endtask

  always @(posedge clk_i) begin : check_children
    child_word_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (children_due.size() == 0) begin
        mismatches++;
        $error("output word at position %0d with nothing expected", m_axis_tdata[4:0]);
      end else begin
        due = children_due.pop_front();
        compare_field("out_position", 32'(due.position), 32'(m_axis_tdata[4:0]));
        compare_field("child_one_gene", 32'(due.child_one), 32'(m_axis_tdata[9:5]));
        compare_field("child_two_gene", 32'(due.child_two), 32'(m_axis_tdata[14:10]));
        compare_field("last", 32'(due.last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("ordered_permutation_crossover_core: mismatch");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_smallest_genome();
    test_cut_points();
    test_broken_parents();
    test_steady_stream();
    test_output_backpressure();
    test_random_rounds();
    settle_block();
    if (mismatches == 0 && children_due.size() == 0) begin
      $display("ordered_permutation_crossover_core: match");
    end else begin
      $display("ordered_permutation_crossover_core: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/opx_pkg.sv
src/opx_gene_ram.sv
src/ordered_permutation_crossover_core.sv
tb/testbench.sv
